FILE: rtl/jbid_pkg.sv
`default_nettype none
package jbid_pkg;

  // opcodes with special handling
  localparam logic [7:0] OP_IINC   = 8'h84;
  localparam logic [7:0] OP_TSW    = 8'hAA;
  localparam logic [7:0] OP_LSW    = 8'hAB;
  localparam logic [7:0] OP_INVI   = 8'hB9;
  localparam logic [7:0] OP_INVD   = 8'hBA;
  localparam logic [7:0] OP_NEWARR = 8'hBC;
  localparam logic [7:0] OP_WIDE   = 8'hC4;
  localparam logic [7:0] OP_MANEW  = 8'hC5;

  // newarray element type range
  localparam logic [31:0] ATYPE_MIN = 32'd4;
  localparam logic [31:0] ATYPE_MAX = 32'd11;

  // record kinds
  localparam logic [1:0] KIND_INSTR  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NEWARRAY  = 3'd1;
  localparam logic [2:0] ERR_WIDE      = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 5;

  typedef struct packed {
    logic       known;
    logic [2:0] len;
  } oplen_t;

  typedef struct packed {
    logic        eom;
    logic [2:0]  err;
    logic [1:0]  kind;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
    logic        wide;
    logic [7:0]  opcode;
    logic [15:0] offset;
  } rec_t;

  // operand byte count of plain opcodes; switches and wide are handled apart
  function automatic oplen_t operand_len(input logic [7:0] op);
    oplen_t r;
    r.known = 1'b1;
    r.len   = 3'd0;
    unique case (op) inside
      [8'h00:8'h0F]:                r.len = 3'd0;
      8'h10, 8'h12:                 r.len = 3'd1;
      8'h11, 8'h13, 8'h14:          r.len = 3'd2;
      [8'h15:8'h19]:                r.len = 3'd1;
      [8'h1A:8'h35]:                r.len = 3'd0;
      [8'h36:8'h3A]:                r.len = 3'd1;
      [8'h3B:8'h83]:                r.len = 3'd0;
      OP_IINC:                      r.len = 3'd2;
      [8'h85:8'h98]:                r.len = 3'd0;
      [8'h99:8'hA8]:                r.len = 3'd2;
      8'hA9:                        r.len = 3'd1;
      [8'hAA:8'hB1]:                r.len = 3'd0;
      [8'hB2:8'hB8]:                r.len = 3'd2;
      OP_INVI, OP_INVD:             r.len = 3'd4;
      8'hBB:                        r.len = 3'd2;
      OP_NEWARR:                    r.len = 3'd1;
      8'hBD:                        r.len = 3'd2;
      8'hBE, 8'hBF:                 r.len = 3'd0;
      8'hC0, 8'hC1:                 r.len = 3'd2;
      [8'hC2:8'hC4]:                r.len = 3'd0;
      OP_MANEW:                     r.len = 3'd3;
      8'hC6, 8'hC7:                 r.len = 3'd2;
      8'hC8, 8'hC9:                 r.len = 3'd4;
      8'hCA:                        r.len = 3'd0;
      8'hFE, 8'hFF:                 r.len = 3'd0;
      default:                      r.known = 1'b0;
    endcase
    return r;
  endfunction

  // loads, stores and ret may follow wide with a 16-bit index
  function automatic logic wide_ok(input logic [7:0] op);
    return ((op >= 8'h15) && (op <= 8'h19)) || ((op >= 8'h36) && (op <= 8'h3A)) ||
           (op == 8'hA9);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/jvm_bytecode_instruction_decoder.sv
`default_nettype none
// jvm bytecode instruction decoder
//
// in channel: one byte of method code per transfer. in_tuser marks the first
// byte of a method (offset and decoder are cleared before it is taken),
// in_tlast marks the last byte.
// out channel: one record per finished instruction, one header record per
// tableswitch/lookupswitch and one record per table entry, plus error records
// for bad newarray types, bad wide opcodes, unknown opcodes and truncated code.
// out_tlast is set on the record made by the method's last byte.
//
// a record is shown in the cycle after the transfer of the byte that completes
// it. throughput: one byte per cycle unless the receiver stalls, set by the
// single decode step between the decode state registers and the output register.
// bytes that complete nothing (operand bytes, switch padding) give no record.
// after the last byte or a halting error, bytes are taken and dropped until a
// byte with in_tuser set arrives.
//
// reset (rst_n low, synchronous) clears the decode state and empties the
// output register. when the receiver stalls, the record is held in the output
// register; a new byte is still taken in the cycle the held record leaves.
module jvm_bytecode_instruction_decoder #(
  parameter int MAX_CODE_BYTES = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [jbid_pkg::IN_DATA_W-1:0]  in_tdata,   // code_byte
  input  wire logic                            in_tuser,   // start_of_code
  input  wire logic                            in_tlast,   // end_of_code
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // instr_offset[15:0], opcode_value[23:16], wide_prefix[24], operand_a[56:25],
  // operand_b[88:57], operand_c[120:89], zero fill[127:121]
  output logic [jbid_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [jbid_pkg::OUT_USER_W-1:0]      out_tuser,  // record_kind[1:0], error_code[4:2]
  output logic                                 out_tlast   // end_of_method
);

  localparam logic [15:0] LastOffset = 16'(MAX_CODE_BYTES - 1);

  // decode phases
  localparam logic [3:0] PH_OP   = 4'd0;
  localparam logic [3:0] PH_WIDE = 4'd1;
  localparam logic [3:0] PH_OPER = 4'd2;
  localparam logic [3:0] PH_PAD  = 4'd3;
  localparam logic [3:0] PH_HDR0 = 4'd4;
  localparam logic [3:0] PH_HDR1 = 4'd5;
  localparam logic [3:0] PH_HDR2 = 4'd6;
  localparam logic [3:0] PH_ENTM = 4'd7;
  localparam logic [3:0] PH_ENTJ = 4'd8;

  // decode state
  logic [15:0]      offset_r, offset_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [2:0]       left_r, left_nxt;
  logic [2:0][31:0] acc_r, acc_nxt;
  logic [31:0]      entries_r, entries_nxt;
  logic             wide_r, wide_nxt;
  logic             halted_r, halted_nxt;
  logic [15:0]      start_r, start_nxt;

  // output register
  logic             out_valid_r;
  jbid_pkg::rec_t   rec_r, rec_nxt;
  logic             emit;

  logic             accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic [7:0]       b;
    logic [15:0]      off;
    logic             last;
    logic             stop;
    logic             cur_halted;
    logic [1:0]       k;
    logic             last_word;
    logic [31:0]      word;
    logic [32:0]      diff;
    logic [31:0]      opa;
    logic [31:0]      opb;
    jbid_pkg::oplen_t ol;

    b    = in_tdata;
    stop = 1'b0;
    emit = 1'b0;
    k    = 2'd0;
    last_word = 1'b0;
    word = 32'd0;
    diff = 33'd0;
    opa  = 32'd0;
    opb  = 32'd0;
    ol   = jbid_pkg::operand_len(b);

    // start of code clears the decoder before the byte is taken
    if (in_tuser) begin
      offset_nxt  = 16'd0;
      phase_nxt   = PH_OP;
      held_nxt    = 8'd0;
      left_nxt    = 3'd0;
      acc_nxt     = '0;
      entries_nxt = 32'd0;
      wide_nxt    = 1'b0;
      cur_halted  = 1'b0;
      start_nxt   = 16'd0;
    end else begin
      offset_nxt  = offset_r;
      phase_nxt   = phase_r;
      held_nxt    = held_r;
      left_nxt    = left_r;
      acc_nxt     = acc_r;
      entries_nxt = entries_r;
      wide_nxt    = wide_r;
      cur_halted  = halted_r;
      start_nxt   = start_r;
    end
    halted_nxt = cur_halted;

    off  = offset_nxt;
    last = in_tlast || (off == LastOffset);

    rec_nxt        = '0;
    rec_nxt.opcode = held_nxt;

    if (!cur_halted) begin
      offset_nxt = off + 16'd1;
      unique case (phase_nxt)
        PH_OP: begin
          start_nxt = off;
          held_nxt  = b;
          wide_nxt  = 1'b0;
          acc_nxt   = '0;
          if (b == jbid_pkg::OP_WIDE) begin
            phase_nxt = PH_WIDE;
          end else if (b == jbid_pkg::OP_TSW || b == jbid_pkg::OP_LSW) begin
            left_nxt  = 3'd4;
            phase_nxt = (off[1:0] == 2'b11) ? PH_HDR0 : PH_PAD;
          end else if (!ol.known) begin
            emit         = 1'b1;
            rec_nxt.kind = jbid_pkg::KIND_ERROR;
            rec_nxt.err  = jbid_pkg::ERR_UNKNOWN;
          end else if (ol.len == 3'd0) begin
            emit         = 1'b1;
            rec_nxt.kind = jbid_pkg::KIND_INSTR;
          end else begin
            left_nxt  = ol.len;
            phase_nxt = PH_OPER;
          end
        end
        PH_WIDE: begin
          held_nxt = b;
          wide_nxt = 1'b1;
          if (jbid_pkg::wide_ok(b)) begin
            left_nxt  = 3'd2;
            phase_nxt = PH_OPER;
          end else if (b == jbid_pkg::OP_IINC) begin
            left_nxt  = 3'd4;
            phase_nxt = PH_OPER;
          end else begin
            emit         = 1'b1;
            stop         = 1'b1;
            rec_nxt.kind = jbid_pkg::KIND_ERROR;
            rec_nxt.err  = jbid_pkg::ERR_WIDE;
          end
        end
        PH_OPER: begin
          acc_nxt[0] = {acc_nxt[0][23:0], b};
          left_nxt   = left_nxt - 3'd1;
          if (left_nxt == 3'd0) begin
            phase_nxt = PH_OP;
            opa = acc_nxt[0];
            opb = 32'd0;
            emit = 1'b1;
            if (wide_nxt) begin
              if (held_nxt == jbid_pkg::OP_IINC) begin
                opa = {16'd0, acc_nxt[0][31:16]};
                opb = {16'd0, acc_nxt[0][15:0]};
              end
            end else if (held_nxt == jbid_pkg::OP_IINC || held_nxt == jbid_pkg::OP_MANEW) begin
              opa = {8'd0, acc_nxt[0][31:8]};
              opb = {24'd0, acc_nxt[0][7:0]};
            end else if (held_nxt == jbid_pkg::OP_INVI) begin
              opa = {16'd0, acc_nxt[0][31:16]};
              opb = {24'd0, acc_nxt[0][15:8]};
            end else if (held_nxt == jbid_pkg::OP_INVD) begin
              opa = {16'd0, acc_nxt[0][31:16]};
            end
            if (!wide_nxt && held_nxt == jbid_pkg::OP_NEWARR &&
                (opa < jbid_pkg::ATYPE_MIN || opa > jbid_pkg::ATYPE_MAX)) begin
              stop         = 1'b1;
              rec_nxt.kind = jbid_pkg::KIND_ERROR;
              rec_nxt.err  = jbid_pkg::ERR_NEWARRAY;
              rec_nxt.a    = opa;
            end else begin
              rec_nxt.kind = jbid_pkg::KIND_INSTR;
              rec_nxt.a    = opa;
              rec_nxt.b    = opb;
            end
          end
        end
        PH_PAD, PH_HDR0, PH_HDR1, PH_HDR2: begin
          // padding runs up to the next 4-byte boundary
          if (phase_nxt != PH_PAD || off[1:0] == 2'b00) begin
            k         = (phase_nxt == PH_PAD) ? 2'd0 : 2'(phase_nxt - PH_HDR0);
            phase_nxt = (phase_nxt == PH_PAD) ? PH_HDR0 : phase_nxt;
            word       = {acc_nxt[k][23:0], b};
            acc_nxt[k] = word;
            left_nxt   = left_nxt - 3'd1;
            last_word  = (held_nxt == jbid_pkg::OP_TSW) ? (k == 2'd2) : (k == 2'd1);
            if (left_nxt == 3'd0) begin
              left_nxt = 3'd4;
              if (!last_word) begin
                phase_nxt = phase_nxt + 4'd1;
              end else begin
                emit         = 1'b1;
                rec_nxt.kind = jbid_pkg::KIND_HEADER;
                rec_nxt.a    = acc_nxt[0];
                rec_nxt.b    = acc_nxt[1];
                if (held_nxt == jbid_pkg::OP_TSW) begin
                  // entry count high - low + 1, signed bounds, saturating
                  diff = {acc_nxt[2][31], acc_nxt[2]} - {acc_nxt[1][31], acc_nxt[1]};
                  if (diff[32]) begin
                    entries_nxt = 32'd0;
                  end else if (diff[31:0] == 32'hFFFF_FFFF) begin
                    entries_nxt = 32'hFFFF_FFFF;
                  end else begin
                    entries_nxt = diff[31:0] + 32'd1;
                  end
                  rec_nxt.c = acc_nxt[2];
                  phase_nxt = PH_ENTJ;
                end else begin
                  entries_nxt = acc_nxt[1][31] ? 32'd0 : acc_nxt[1];
                  phase_nxt   = PH_ENTM;
                  acc_nxt[0]  = 32'd0;
                end
                acc_nxt[2] = 32'd0;
                if (entries_nxt == 32'd0) begin
                  phase_nxt = PH_OP;
                end
              end
            end
          end
        end
        PH_ENTM: begin
          acc_nxt[0] = {acc_nxt[0][23:0], b};
          left_nxt   = left_nxt - 3'd1;
          if (left_nxt == 3'd0) begin
            left_nxt  = 3'd4;
            phase_nxt = PH_ENTJ;
          end
        end
        PH_ENTJ: begin
          acc_nxt[2] = {acc_nxt[2][23:0], b};
          left_nxt   = left_nxt - 3'd1;
          if (left_nxt == 3'd0) begin
            emit         = 1'b1;
            rec_nxt.kind = jbid_pkg::KIND_ENTRY;
            rec_nxt.a    = (held_nxt == jbid_pkg::OP_TSW) ? acc_nxt[1] : acc_nxt[0];
            rec_nxt.b    = acc_nxt[2];
            if (held_nxt == jbid_pkg::OP_TSW) begin
              acc_nxt[1] = acc_nxt[1] + 32'd1;
            end
            acc_nxt[0]  = 32'd0;
            acc_nxt[2]  = 32'd0;
            left_nxt    = 3'd4;
            entries_nxt = entries_nxt - 32'd1;
            if (entries_nxt == 32'd0) begin
              phase_nxt = PH_OP;
            end else begin
              phase_nxt = (held_nxt == jbid_pkg::OP_TSW) ? PH_ENTJ : PH_ENTM;
            end
          end
        end
        default: begin
          phase_nxt = PH_OP;
        end
      endcase

      // last byte inside an unfinished instruction replaces any record but a halting error
      if (last && !stop && phase_nxt != PH_OP) begin
        emit         = 1'b1;
        rec_nxt      = '0;
        rec_nxt.kind = jbid_pkg::KIND_ERROR;
        rec_nxt.err  = jbid_pkg::ERR_TRUNCATED;
      end
      rec_nxt.offset = start_nxt;
      rec_nxt.opcode = held_nxt;
      rec_nxt.wide   = (rec_nxt.kind == jbid_pkg::KIND_HEADER ||
                        rec_nxt.kind == jbid_pkg::KIND_ENTRY) ? 1'b0 : wide_nxt;
      // unknown opcode records never carry the wide flag
      if (rec_nxt.err == jbid_pkg::ERR_UNKNOWN) begin
        rec_nxt.wide = 1'b0;
      end
      rec_nxt.eom = last && emit;
      if (last || stop) begin
        halted_nxt = 1'b1;
        phase_nxt  = PH_OP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= 16'd0;
      phase_r   <= PH_OP;
      held_r    <= 8'd0;
      left_r    <= 3'd0;
      acc_r     <= '0;
      entries_r <= 32'd0;
      wide_r    <= 1'b0;
      halted_r  <= 1'b0;
      start_r   <= 16'd0;
    end else if (accept) begin
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      left_r    <= left_nxt;
      acc_r     <= acc_nxt;
      entries_r <= entries_nxt;
      wide_r    <= wide_nxt;
      halted_r  <= halted_nxt;
      start_r   <= start_nxt;
    end
  end

  // output register: loads on a byte that makes a record, empties on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, rec_r.c, rec_r.b, rec_r.a, rec_r.wide, rec_r.opcode, rec_r.offset};
  assign out_tuser  = {rec_r.err, rec_r.kind};
  assign out_tlast  = rec_r.eom;

endmodule
`default_nettype wire

FILE: rtl/jbid_checker.sv
`default_nettype none
module jbid_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [jbid_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [jbid_pkg::OUT_USER_W-1:0] out_tuser,
  input wire logic                            out_tlast
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) &&
                                  $stable(out_tlast))
    else $error("stalled record changed");

  // input is only held off by a waiting record
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting record");

  // error records and only those carry an error code
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser[1:0] == jbid_pkg::KIND_ERROR) ==
                    (out_tuser[4:2] != jbid_pkg::ERR_NONE)))
    else $error("record kind and error code disagree");

  // switch records belong to a switch opcode without wide
  a_switch_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == jbid_pkg::KIND_HEADER ||
                   out_tuser[1:0] == jbid_pkg::KIND_ENTRY)
    |-> !out_tdata[24] && (out_tdata[23:16] == jbid_pkg::OP_TSW ||
                           out_tdata[23:16] == jbid_pkg::OP_LSW))
    else $error("switch record with wrong opcode");

endmodule

bind jvm_bytecode_instruction_decoder jbid_checker u_jbid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
